>>> design/sbc_pkg.sv
// Shared constants and types for the segment box clipper.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sbc_pkg;

  // Fixed-point widths
  localparam int unsigned CW = 32;   // coordinate, Q16.16
  localparam int unsigned UW = 33;   // direction component
  localparam int unsigned QW = 17;   // segment parameter, Q1.16
  localparam int unsigned PW = 51;   // parameter times direction
  localparam int unsigned SW = 52;   // coordinate at scale 2^16

  localparam logic [QW-1:0] ONE_Q16 = 17'h10000;

  // Divider layout: quotient bits resolved per stage
  localparam int unsigned DIV_STEPS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES =
    (QW + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;

  localparam int unsigned NUM_AXES = 3;
  // Input register, per-axis stages, interpolation and output register
  localparam int unsigned AXIS_LATENCY = DIV_STAGES + 4;
  localparam int unsigned PIPE_LATENCY = 1 + NUM_AXES * AXIS_LATENCY + 2;

  // Word carried down the pipe; the axis in work is always at index 0
  typedef struct packed {
    logic [2:0][CW-1:0] b;
    logic [2:0][UW-1:0] u;
    logic [2:0][CW-1:0] lo;
    logic [2:0][CW-1:0] hi;
    logic [QW-1:0]      tb;
    logic [QW-1:0]      te;
    logic               live;
  } sbc_item_t;

  // Per-axis division decisions, travelling beside the divider
  typedef struct packed {
    logic need_b;
    logic need_e;
    logic zero_b;
    logic zero_e;
    logic sat_b;
    logic sat_e;
  } sbc_axis_ctl_t;

endpackage

`default_nettype wire

>>> design/sbc_div.sv
// Pipelined restoring divider giving a 17-bit quotient of dividend*2^16 / divisor.
// Depends on sbc_pkg; dividend must be below twice the divisor.
`default_nettype none

module sbc_div import sbc_pkg::*; (
  input  logic          clk_i,
  input  logic [UW-1:0] divisor_i,
  input  logic [UW-1:0] dividend_i,
  output logic [QW-1:0] quot_o
);

  logic [UW:0]   rem_q  [DIV_STAGES];
  logic [QW-1:0] quot_q [DIV_STAGES];
  logic [UW-1:0] dsr_q  [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [UW:0]   rem_in;
    logic [QW-1:0] quot_in;
    logic [UW-1:0] dsr_in;
    logic [UW:0]   rem_d;
    logic [QW-1:0] quot_d;

    if (s == 0) begin : g_first
      assign rem_in  = {1'b0, dividend_i};
      assign quot_in = '0;
      assign dsr_in  = divisor_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign quot_in = quot_q[s-1];
      assign dsr_in  = dsr_q[s-1];
    end

    // Resolve up to DIV_STEPS_PER_STAGE quotient bits, MSB first
    always_comb begin
      rem_d  = rem_in;
      quot_d = quot_in;
      for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
        if (s * DIV_STEPS_PER_STAGE + j < QW) begin
          if (s * DIV_STEPS_PER_STAGE + j != 0) begin
            rem_d = {rem_d[UW-1:0], 1'b0};
          end
          if (rem_d >= {1'b0, dsr_in}) begin
            rem_d = rem_d - {1'b0, dsr_in};
            quot_d[QW-1-(s*DIV_STEPS_PER_STAGE+j)] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= rem_d;
      quot_q[s] <= quot_d;
      dsr_q[s]  <= dsr_in;
    end
  end

  assign quot_o = quot_q[DIV_STAGES-1];

endmodule

`default_nettype wire

>>> design/sbc_axis.sv
// One clipping axis: rejection tests and tightening of tB and tE.
// Depends on sbc_pkg and sbc_div; works on index 0 and rotates the axes on exit.
`default_nettype none

module sbc_axis import sbc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [15:0] md_i,
  input  logic       valid_i,
  input  sbc_item_t  item_i,
  output logic       valid_o,
  output sbc_item_t  item_o
);

  // Stage 1: parameter times direction
  logic signed [PW-1:0] pb_d, pe_d, pb1_q, pe1_q;
  sbc_item_t            item1_q;
  logic                 v1_q;

  always_comb begin
    pb_d = $signed({1'b0, item_i.tb}) * $signed(item_i.u[0]);
    pe_d = $signed({1'b0, item_i.te}) * $signed(item_i.u[0]);
  end

  always_ff @(posedge clk_i) begin
    item1_q <= item_i;
    pb1_q   <= pb_d;
    pe1_q   <= pe_d;
  end

  // Stage 2: endpoints at scale 2^16 and corner offsets
  logic signed [SW-1:0] bs_d, es_d, bs2_q, es2_q;
  logic signed [UW-1:0] dl_d, dh_d, dl2_q, dh2_q;
  sbc_item_t            item2_q;
  logic                 v2_q;

  always_comb begin
    bs_d = $signed({{4{item1_q.b[0][CW-1]}}, item1_q.b[0], 16'h0})
         + $signed({pb1_q[PW-1], pb1_q});
    es_d = $signed({{4{item1_q.b[0][CW-1]}}, item1_q.b[0], 16'h0})
         + $signed({pe1_q[PW-1], pe1_q});
    dl_d = $signed({item1_q.lo[0][CW-1], item1_q.lo[0]})
         - $signed({item1_q.b[0][CW-1], item1_q.b[0]});
    dh_d = $signed({item1_q.hi[0][CW-1], item1_q.hi[0]})
         - $signed({item1_q.b[0][CW-1], item1_q.b[0]});
  end

  always_ff @(posedge clk_i) begin
    item2_q <= item1_q;
    bs2_q   <= bs_d;
    es2_q   <= es_d;
    dl2_q   <= dl_d;
    dh2_q   <= dh_d;
  end

  // Stage 3: box tests, near-zero check, divider operands
  logic signed [SW-1:0] los, his;
  logic signed [UW-1:0] nb, ne;
  logic                 uneg, near_zero, rej;
  logic [UW-1:0]        absu, anb, ane;
  sbc_axis_ctl_t        ctl_d, ctl3_q;
  sbc_item_t            item3_d, item3_q;
  logic [UW-1:0]        ad3_q, anb3_q, ane3_q;
  logic                 v3_q;

  always_comb begin
    los   = $signed({{4{item2_q.lo[0][CW-1]}}, item2_q.lo[0], 16'h0});
    his   = $signed({{4{item2_q.hi[0][CW-1]}}, item2_q.hi[0], 16'h0});
    uneg  = item2_q.u[0][UW-1];
    absu  = uneg ? (~item2_q.u[0] + 1'b1) : item2_q.u[0];
    near_zero = (absu < {17'h0, md_i}) || (absu == '0);
    nb    = uneg ? dh2_q : dl2_q;
    ne    = uneg ? dl2_q : dh2_q;
    anb   = nb[UW-1] ? (~nb + 1'b1) : nb;
    ane   = ne[UW-1] ? (~ne + 1'b1) : ne;
    if (uneg) begin
      rej          = (bs2_q < los) || (es2_q > his);
      ctl_d.need_b = bs2_q > his;
      ctl_d.need_e = es2_q < los;
    end else begin
      rej          = (bs2_q > his) || (es2_q < los);
      ctl_d.need_b = bs2_q < los;
      ctl_d.need_e = es2_q > his;
    end
    rej          = rej || ((ctl_d.need_b || ctl_d.need_e) && near_zero);
    ctl_d.zero_b = nb[UW-1] != uneg;
    ctl_d.zero_e = ne[UW-1] != uneg;
    ctl_d.sat_b  = {1'b0, anb} >= {absu, 1'b0};
    ctl_d.sat_e  = {1'b0, ane} >= {absu, 1'b0};
    item3_d      = item2_q;
    item3_d.live = item2_q.live && !rej;
  end

  always_ff @(posedge clk_i) begin
    item3_q <= item3_d;
    ctl3_q  <= ctl_d;
    ad3_q   <= absu;
    anb3_q  <= anb;
    ane3_q  <= ane;
  end

  // Division of both corner offsets
  logic [QW-1:0] quot_b, quot_e;

  sbc_div u_div_b (
    .clk_i      (clk_i),
    .divisor_i  (ad3_q),
    .dividend_i (anb3_q),
    .quot_o     (quot_b)
  );

  sbc_div u_div_e (
    .clk_i      (clk_i),
    .divisor_i  (ad3_q),
    .dividend_i (ane3_q),
    .quot_o     (quot_e)
  );

  // Delay line alongside the divider
  sbc_item_t     item_dl_q [DIV_STAGES];
  sbc_axis_ctl_t ctl_dl_q  [DIV_STAGES];
  logic [DIV_STAGES-1:0] v_dl_q;

  always_ff @(posedge clk_i) begin
    item_dl_q[0] <= item3_q;
    ctl_dl_q[0]  <= ctl3_q;
    for (int i = 1; i < DIV_STAGES; i++) begin
      item_dl_q[i] <= item_dl_q[i-1];
      ctl_dl_q[i]  <= ctl_dl_q[i-1];
    end
  end

  // Final stage: clamp quotients, update parameters, rotate axes
  sbc_item_t     item_last, item_d, item_q;
  sbc_axis_ctl_t ctl_last;
  logic [QW-1:0] tb_sel, te_sel;
  logic          v_q;

  assign item_last = item_dl_q[DIV_STAGES-1];
  assign ctl_last  = ctl_dl_q[DIV_STAGES-1];

  always_comb begin
    if (ctl_last.zero_b) begin
      tb_sel = '0;
    end else if (ctl_last.sat_b || quot_b > ONE_Q16) begin
      tb_sel = ONE_Q16;
    end else begin
      tb_sel = quot_b;
    end
    if (ctl_last.zero_e) begin
      te_sel = '0;
    end else if (ctl_last.sat_e || quot_e > ONE_Q16) begin
      te_sel = ONE_Q16;
    end else begin
      te_sel = quot_e;
    end
    item_d    = item_last;
    item_d.tb = ctl_last.need_b ? tb_sel : item_last.tb;
    item_d.te = ctl_last.need_e ? te_sel : item_last.te;
    item_d.b  = {item_last.b[0],  item_last.b[2:1]};
    item_d.u  = {item_last.u[0],  item_last.u[2:1]};
    item_d.lo = {item_last.lo[0], item_last.lo[2:1]};
    item_d.hi = {item_last.hi[0], item_last.hi[2:1]};
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v_dl_q <= '0;
      v_q    <= 1'b0;
    end else begin
      v1_q   <= valid_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v_dl_q <= {v_dl_q[DIV_STAGES-2:0], v3_q};
      v_q    <= v_dl_q[DIV_STAGES-1];
    end
  end

  assign valid_o = v_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

>>> design/sbc_lerp.sv
// Output stages: parameter ordering, endpoint interpolation, miss zeroing.
// Depends on sbc_pkg.
`default_nettype none

module sbc_lerp import sbc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  sbc_item_t          item_i,
  output logic               valid_o,
  output logic               hit_o,
  output logic [2:0][CW-1:0] clip_begin_o,
  output logic [2:0][CW-1:0] clip_end_o,
  output logic [QW-1:0]      param_begin_o,
  output logic [QW-1:0]      exit_param_o
);

  // Stage 1: raise tE to tB, form t*u for every axis
  logic [QW-1:0]            te_fix;
  logic signed [PW-1:0]     pb_d [3];
  logic signed [PW-1:0]     pe_d [3];
  logic signed [PW-1:0]     pb_q [3];
  logic signed [PW-1:0]     pe_q [3];
  logic [2:0][CW-1:0]       b_q;
  logic [QW-1:0]            tb_q, te_q;
  logic                     live_q, v1_q;

  always_comb begin
    te_fix = (item_i.te < item_i.tb) ? item_i.tb : item_i.te;
    for (int i = 0; i < 3; i++) begin
      pb_d[i] = $signed({1'b0, item_i.tb}) * $signed(item_i.u[i]);
      pe_d[i] = $signed({1'b0, te_fix}) * $signed(item_i.u[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    pb_q   <= pb_d;
    pe_q   <= pe_d;
    b_q    <= item_i.b;
    tb_q   <= item_i.tb;
    te_q   <= te_fix;
    live_q <= item_i.live;
  end

  // Stage 2: round to nearest, ties up, and zero on a miss
  logic signed [SW-1:0] rb, re;
  logic [2:0][CW-1:0]   cb_d, ce_d, cb_q, ce_q;
  logic [QW-1:0]        tb_o_q, te_o_q;
  logic                 hit_q, v2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rb      = $signed({pb_q[i][PW-1], pb_q[i]}) + $signed(SW'(32768));
      re      = $signed({pe_q[i][PW-1], pe_q[i]}) + $signed(SW'(32768));
      cb_d[i] = live_q ? (b_q[i] + rb[47:16]) : '0;
      ce_d[i] = live_q ? (b_q[i] + re[47:16]) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    cb_q   <= cb_d;
    ce_q   <= ce_d;
    tb_o_q <= live_q ? tb_q : '0;
    te_o_q <= live_q ? te_q : '0;
    hit_q  <= live_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign valid_o       = v2_q;
  assign hit_o         = hit_q;
  assign clip_begin_o  = cb_q;
  assign clip_end_o    = ce_q;
  assign param_begin_o = tb_o_q;
  assign exit_param_o  = te_o_q;

endmodule

`default_nettype wire

>>> design/segment_box_clip_3d_top.sv
// Top level of the 3D segment box clipper (Liang-Barsky, Q16.16).
// Pipeline: input register, then 13 stages per axis of which 9 are the divider,
// then two output stages, after which valid_o strobes for each accepted word.
// Throughput: one word per cycle; busy_o is always low and results cannot stall.
// Reset clears all valid bits and sets min_direction to 1; payload is not reset.
`default_nettype none

module segment_box_clip_3d_top import sbc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] begin_x_i,
  input  logic [31:0] begin_y_i,
  input  logic [31:0] begin_z_i,
  input  logic [31:0] end_x_i,
  input  logic [31:0] end_y_i,
  input  logic [31:0] end_z_i,
  input  logic [31:0] box_low_x_i,
  input  logic [31:0] box_low_y_i,
  input  logic [31:0] box_low_z_i,
  input  logic [31:0] box_high_x_i,
  input  logic [31:0] box_high_y_i,
  input  logic [31:0] box_high_z_i,
  output logic        valid_o,
  output logic        hit_o,
  output logic [31:0] clip_begin_x_o,
  output logic [31:0] clip_begin_y_o,
  output logic [31:0] clip_begin_z_o,
  output logic [31:0] clip_end_x_o,
  output logic [31:0] clip_end_y_o,
  output logic [31:0] clip_end_z_o,
  output logic [16:0] param_begin_o,
  output logic [16:0] exit_param_o
);

  // Configuration register
  logic [15:0] md_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      md_q <= 16'd1;
    end else if (cfg_we_i) begin
      md_q <= cfg_wdata_i;
    end
  end

  assign busy_o = 1'b0;

  // Input register: begin point, box, direction and initial parameters
  logic [2:0][CW-1:0] in_b, in_e;
  sbc_item_t          item0_d, item0_q;
  logic               v0_q;

  always_comb begin
    in_b = {begin_z_i, begin_y_i, begin_x_i};
    in_e = {end_z_i, end_y_i, end_x_i};
    item0_d.b  = in_b;
    item0_d.lo = {box_low_z_i, box_low_y_i, box_low_x_i};
    item0_d.hi = {box_high_z_i, box_high_y_i, box_high_x_i};
    for (int i = 0; i < 3; i++) begin
      item0_d.u[i] = {in_e[i][CW-1], in_e[i]} - {in_b[i][CW-1], in_b[i]};
    end
    item0_d.tb   = '0;
    item0_d.te   = ONE_Q16;
    item0_d.live = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      item0_q <= item0_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start_i && !busy_o;
    end
  end

  // Axis chain x, y, z
  sbc_item_t            ax_item [NUM_AXES+1];
  logic [NUM_AXES:0]    ax_valid;

  assign ax_item[0]  = item0_q;
  assign ax_valid[0] = v0_q;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    sbc_axis u_axis (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .md_i    (md_q),
      .valid_i (ax_valid[a]),
      .item_i  (ax_item[a]),
      .valid_o (ax_valid[a+1]),
      .item_o  (ax_item[a+1])
    );
  end

  // Interpolation and output
  logic [2:0][CW-1:0] clip_b, clip_e;

  sbc_lerp u_lerp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (ax_valid[NUM_AXES]),
    .item_i        (ax_item[NUM_AXES]),
    .valid_o       (valid_o),
    .hit_o         (hit_o),
    .clip_begin_o  (clip_b),
    .clip_end_o    (clip_e),
    .param_begin_o (param_begin_o),
    .exit_param_o  (exit_param_o)
  );

  assign clip_begin_x_o = clip_b[0];
  assign clip_begin_y_o = clip_b[1];
  assign clip_begin_z_o = clip_b[2];
  assign clip_end_x_o   = clip_e[0];
  assign clip_end_y_o   = clip_e[1];
  assign clip_end_z_o   = clip_e[2];

  // Checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && hit_o |-> exit_param_o >= param_begin_o)
    else $error("clipped end parameter below begin parameter");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && hit_o |-> param_begin_o <= ONE_Q16 && exit_param_o <= ONE_Q16)
    else $error("segment parameter out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##PIPE_LATENCY valid_o)
    else $error("accepted word did not produce a result strobe");

endmodule

`default_nettype wire
